@@ design/hfsm_pkg.sv @@
package hfsm_pkg;

    localparam int HFSM_MAX_STATES      = 32;
    localparam int HFSM_MAX_TRANSITIONS = 64;

    typedef enum logic [1:0] {
        OP_DEFINE   = 2'd0,
        OP_ADD      = 2'd1,
        OP_INIT     = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SSCAN,
        ST_TSCAN,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic [7:0] parent;
        logic [7:0] id;
    } state_entry_t;

    typedef struct packed {
        logic [7:0] pri;
        logic [7:0] target;
        logic [7:0] evt;
        logic [7:0] source;
    } trans_entry_t;

    typedef struct packed {
        logic hit_a;
        logic hit_b;
        logic t_better;
    } match_t;

endpackage

@@ design/hierarchical_fsm_event_dispatch_unit.sv @@
// Work per request: define, add and set-initial take one state-table scan; dispatch takes
// one transition scan per level visited and one state scan per level without a match (no
// scan with no current state). Throughput: one request at a time; s_axis_tready is high
// only while the sequencer is idle. Reset (rst_n low, asynchronous): counts, current state and
// output valid clear; table contents stay undefined until written.
module hierarchical_fsm_event_dispatch_unit #(
    parameter int MAX_STATES      = hfsm_pkg::HFSM_MAX_STATES,
    parameter int MAX_TRANSITIONS = hfsm_pkg::HFSM_MAX_TRANSITIONS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: state_id[7:0], parent_id[15:8], event_id[23:16], target_id[31:24],
    //        priority_req[39:32]
    input  logic [39:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: current_state[7:0]
    output logic [7:0]  m_axis_tdata,
    // tuser: status[0]
    output logic [0:0]  m_axis_tuser
);

    import hfsm_pkg::*;

    localparam int SAW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int TAW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int SCW = $clog2(MAX_STATES + 1);
    localparam int TCW = $clog2(MAX_TRANSITIONS + 1);
    localparam int IW  = (SCW > TCW) ? SCW : TCW;

    // sequencer state
    seq_state_t     state_reg, state_next;
    op_t            op_reg, op_next;
    logic [7:0]     sid_reg, sid_next;
    logic [7:0]     pid_reg, pid_next;
    logic [7:0]     eid_reg, eid_next;
    logic [7:0]     tid_reg, tid_next;
    logic [7:0]     pri_reg, pri_next;
    logic [7:0]     key_a_reg, key_a_next;   // searched id, or the current level on dispatch
    logic [7:0]     key_b_reg, key_b_next;

    // scan engine
    logic [IW-1:0]  issue_reg, issue_next;
    logic           chk_reg, chk_next;       // read data of last cycle is valid
    logic           hit_a_reg, hit_a_next;
    logic           hit_b_reg, hit_b_next;
    logic [7:0]     par_reg, par_next;
    logic           found_reg, found_next;
    logic [7:0]     best_pri_reg, best_pri_next;
    logic [7:0]     best_tgt_reg, best_tgt_next;

    // table bookkeeping and result
    logic [SCW-1:0] scount_reg, scount_next;
    logic [TCW-1:0] tcount_reg, tcount_next;
    logic [7:0]     current_reg, current_next;
    logic           fail_reg, fail_next;
    logic           m_valid_reg, m_valid_next;
    logic           m_status_reg, m_status_next;
    logic [7:0]     m_state_reg, m_state_next;

    // memory ports
    logic             s_we, s_re, t_we, t_re;
    logic [15:0]      s_rdata;
    logic [31:0]      t_rdata;
    state_entry_t     s_entry, s_wentry;
    trans_entry_t     t_entry, t_wentry;
    match_t           match;

    logic [IW-1:0]    scan_limit;
    logic             issuing;
    logic             ok;
    logic [7:0]       next_level;

    assign s_entry  = state_entry_t'(s_rdata);
    assign t_entry  = trans_entry_t'(t_rdata);
    assign s_wentry = '{parent: pid_reg, id: sid_reg};
    assign t_wentry = '{pri: pri_reg, target: tid_reg, evt: eid_reg, source: sid_reg};

    hfsm_ram #(
        .WIDTH (16),
        .DEPTH (MAX_STATES),
        .AW    (SAW)
    ) u_state_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (scount_reg[SAW-1:0]),
        .wdata (s_wentry),
        .re    (s_re),
        .raddr (issue_reg[SAW-1:0]),
        .rdata (s_rdata)
    );

    hfsm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TRANSITIONS),
        .AW    (TAW)
    ) u_trans_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (tcount_reg[TAW-1:0]),
        .wdata (t_wentry),
        .re    (t_re),
        .raddr (issue_reg[TAW-1:0]),
        .rdata (t_rdata)
    );

    // one compare unit serves both table scans
    hfsm_match_unit u_match (
        .s_entry  (s_entry),
        .t_entry  (t_entry),
        .key_a    (key_a_reg),
        .key_b    (key_b_reg),
        .key_evt  (eid_reg),
        .found    (found_reg),
        .best_pri (best_pri_reg),
        .best_tgt (best_tgt_reg),
        .result   (match)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_state_reg;
    assign m_axis_tuser  = m_status_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        sid_next      = sid_reg;
        pid_next      = pid_reg;
        eid_next      = eid_reg;
        tid_next      = tid_reg;
        pri_next      = pri_reg;
        key_a_next    = key_a_reg;
        key_b_next    = key_b_reg;
        issue_next    = issue_reg;
        chk_next      = chk_reg;
        hit_a_next    = hit_a_reg;
        hit_b_next    = hit_b_reg;
        par_next      = par_reg;
        found_next    = found_reg;
        best_pri_next = best_pri_reg;
        best_tgt_next = best_tgt_reg;
        scount_next   = scount_reg;
        tcount_next   = tcount_reg;
        current_next  = current_reg;
        fail_next     = fail_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_state_next  = m_state_reg;
        s_we          = 1'b0;
        s_re          = 1'b0;
        t_we          = 1'b0;
        t_re          = 1'b0;
        ok            = 1'b0;
        next_level    = 8'd0;

        scan_limit = (state_reg == ST_TSCAN) ? IW'(tcount_reg) : IW'(scount_reg);
        issuing    = (issue_reg < scan_limit);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    // latch the request and arm a fresh scan
                    op_next    = op_t'(s_axis_tuser);
                    sid_next   = s_axis_tdata[7:0];
                    pid_next   = s_axis_tdata[15:8];
                    eid_next   = s_axis_tdata[23:16];
                    tid_next   = s_axis_tdata[31:24];
                    pri_next   = s_axis_tdata[39:32];
                    issue_next = '0;
                    chk_next   = 1'b0;
                    hit_a_next = 1'b0;
                    hit_b_next = 1'b0;
                    found_next = 1'b0;
                    key_a_next = s_axis_tdata[7:0];
                    key_b_next = s_axis_tdata[15:8];
                    case (op_t'(s_axis_tuser))
                        OP_DEFINE:
                        begin
                            state_next = ST_SSCAN;
                        end
                        OP_ADD:
                        begin
                            key_b_next = s_axis_tdata[31:24];
                            state_next = ST_SSCAN;
                        end
                        OP_INIT:
                        begin
                            state_next = ST_SSCAN;
                        end
                        OP_DISPATCH:
                        begin
                            // no current state: drop the event at once
                            if (current_reg == 8'd0)
                            begin
                                fail_next  = 1'b1;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                key_a_next = current_reg;
                                state_next = ST_TSCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_SSCAN;
                        end
                    endcase
                end
            end

            ST_SSCAN:
            begin
                if (issuing)
                begin
                    s_re       = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                chk_next = issuing;
                if (chk_reg)
                begin
                    if (match.hit_a)
                    begin
                        hit_a_next = 1'b1;
                        par_next   = s_entry.parent;
                    end
                    if (match.hit_b)
                    begin
                        hit_b_next = 1'b1;
                    end
                end
                if (!issuing && !chk_reg)
                begin
                    case (op_reg)
                        OP_DEFINE:
                        begin
                            ok = (sid_reg != 8'd0) && !hit_a_reg &&
                                 ((pid_reg == 8'd0) || hit_b_reg) &&
                                 (scount_reg < SCW'(MAX_STATES));
                            s_we        = ok;
                            scount_next = ok ? scount_reg + 1'b1 : scount_reg;
                            fail_next   = !ok;
                            state_next  = ST_OUT;
                        end
                        OP_ADD:
                        begin
                            ok = (eid_reg != 8'd0) && hit_a_reg && hit_b_reg &&
                                 (tcount_reg < TCW'(MAX_TRANSITIONS));
                            t_we        = ok;
                            tcount_next = ok ? tcount_reg + 1'b1 : tcount_reg;
                            fail_next   = !ok;
                            state_next  = ST_OUT;
                        end
                        OP_INIT:
                        begin
                            if (hit_a_reg)
                            begin
                                current_next = sid_reg;
                            end
                            fail_next  = !hit_a_reg;
                            state_next = ST_OUT;
                        end
                        OP_DISPATCH:
                        begin
                            // climb to the parent of the level just searched
                            next_level = hit_a_reg ? par_reg : 8'd0;
                            if (next_level == 8'd0)
                            begin
                                fail_next  = 1'b1;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                key_a_next = next_level;
                                issue_next = '0;
                                chk_next   = 1'b0;
                                found_next = 1'b0;
                                state_next = ST_TSCAN;
                            end
                        end
                        default:
                        begin
                            fail_next  = 1'b1;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_TSCAN:
            begin
                if (issuing)
                begin
                    t_re       = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                chk_next = issuing;
                if (chk_reg && match.t_better)
                begin
                    found_next    = 1'b1;
                    best_pri_next = t_entry.pri;
                    best_tgt_next = t_entry.target;
                end
                if (!issuing && !chk_reg)
                begin
                    if (found_reg)
                    begin
                        current_next = best_tgt_reg;
                        fail_next    = 1'b0;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        // nothing at this level: look up its parent
                        issue_next = '0;
                        chk_next   = 1'b0;
                        hit_a_next = 1'b0;
                        hit_b_next = 1'b0;
                        state_next = ST_SSCAN;
                    end
                end
            end

            ST_OUT:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = fail_reg;
                    m_state_next  = current_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            chk_reg     <= 1'b0;
            scount_reg  <= '0;
            tcount_reg  <= '0;
            current_reg <= 8'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_reg     <= chk_next;
            scount_reg  <= scount_next;
            tcount_reg  <= tcount_next;
            current_reg <= current_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        sid_reg      <= sid_next;
        pid_reg      <= pid_next;
        eid_reg      <= eid_next;
        tid_reg      <= tid_next;
        pri_reg      <= pri_next;
        key_a_reg    <= key_a_next;
        key_b_reg    <= key_b_next;
        issue_reg    <= issue_next;
        hit_a_reg    <= hit_a_next;
        hit_b_reg    <= hit_b_next;
        par_reg      <= par_next;
        found_reg    <= found_next;
        best_pri_reg <= best_pri_next;
        best_tgt_reg <= best_tgt_next;
        fail_reg     <= fail_next;
        m_status_reg <= m_status_next;
        m_state_reg  <= m_state_next;
    end

endmodule

@@ design/hfsm_ram.sv @@
module hfsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/hfsm_match_unit.sv @@
module hfsm_match_unit (
    input  hfsm_pkg::state_entry_t s_entry,
    input  hfsm_pkg::trans_entry_t t_entry,
    input  logic [7:0]             key_a,
    input  logic [7:0]             key_b,
    input  logic [7:0]             key_evt,
    input  logic                   found,
    input  logic [7:0]             best_pri,
    input  logic [7:0]             best_tgt,
    output hfsm_pkg::match_t       result
);

    import hfsm_pkg::*;

    logic t_hit;

    always_comb
    begin
        t_hit          = (t_entry.source == key_a) && (t_entry.evt == key_evt);
        result.hit_a   = (s_entry.id == key_a);
        result.hit_b   = (s_entry.id == key_b);
        // higher priority wins, equal priority goes to the smaller target
        result.t_better = t_hit && (!found || (t_entry.pri > best_pri) ||
                          ((t_entry.pri == best_pri) && (t_entry.target < best_tgt)));
    end

endmodule

@@ tb/hierarchical_fsm_event_dispatch_unit_tb.sv @@
module hierarchical_fsm_event_dispatch_unit_tb;
    import hfsm_pkg::*;

    localparam int RUN_ITEMS   = 1450;
    localparam int DIR_ROWS    = 25;
    localparam int SETTLE      = 40;
    // Worst case is a dispatch that climbs a full 32-level chain against full tables
    // on every request, plus stalls; take that worst case several times over.
    localparam int CYCLE_LIMIT = 20_000_000;

    // One row of the directed table; typed rows carry their expected reply inline.
    typedef struct {
        op_t        op;
        logic [7:0] sid;
        logic [7:0] pid;
        logic [7:0] eid;
        logic [7:0] tid;
        logic [7:0] pri;
        bit         typed;
        logic       status;
        logic [7:0] cur;
    } dir_row_t;

    typedef struct {
        logic       status;
        logic [7:0] cur;
        int         seq;
    } reply_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Shadow of the engine: state table, transition table, counts and current state.
    state_entry_t state_mem [HFSM_MAX_STATES];
    trans_entry_t trans_mem [HFSM_MAX_TRANSITIONS];
    int           state_cnt = 0;
    int           trans_cnt = 0;
    logic [7:0]   cur_state = 8'd0;

    reply_t pending_replies [$];

    int cycle_count   = 0;
    int sent_count    = 0;
    int replies_seen  = 0;
    int mismatches    = 0;
    int moves_taken   = 0;
    int burst_left    = 0;
    int ready_run     = 0;
    bit ready_level   = 1'b1;

    // Directed table: reset behavior, every rejection rule but full tables, priority and tie-break,
    // parent-chain climb, event zero and duplicate transitions.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{OP_DISPATCH, 8'd0,   8'd0,  8'd5, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_INIT,     8'd0,   8'd0,  8'd0, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_INIT,     8'd77,  8'd0,  8'd0, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_DEFINE,   8'd0,   8'd0,  8'd0, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_DEFINE,   8'd1,   8'd0,  8'd0, 8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
        '{OP_DEFINE,   8'd1,   8'd0,  8'd0, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_DEFINE,   8'd2,   8'd99, 8'd0, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_DEFINE,   8'd2,   8'd1,  8'd0, 8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
        '{OP_DEFINE,   8'd255, 8'd2,  8'd0, 8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
        '{OP_ADD,      8'd0,   8'd0,  8'd5, 8'd1,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_ADD,      8'd1,   8'd0,  8'd0, 8'd2,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_ADD,      8'd1,   8'd0,  8'd5, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_ADD,      8'd77,  8'd0,  8'd5, 8'd1,   8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_ADD,      8'd1,   8'd0,  8'd5, 8'd77,  8'd0,   1'b1, 1'b1, 8'd0},
        '{OP_ADD,      8'd1,   8'd0,  8'd5, 8'd255, 8'd0,   1'b1, 1'b0, 8'd0},
        '{OP_ADD,      8'd1,   8'd0,  8'd5, 8'd2,   8'd0,   1'b1, 1'b0, 8'd0},
        '{OP_ADD,      8'd2,   8'd0,  8'd7, 8'd1,   8'd255, 1'b1, 1'b0, 8'd0},
        '{OP_ADD,      8'd2,   8'd0,  8'd7, 8'd255, 8'd254, 1'b0, 1'b0, 8'd0},
        '{OP_INIT,     8'd255, 8'd0,  8'd0, 8'd0,   8'd0,   1'b1, 1'b0, 8'd255},
        '{OP_DISPATCH, 8'd0,   8'd0,  8'd0, 8'd0,   8'd0,   1'b1, 1'b1, 8'd255},
        '{OP_DISPATCH, 8'd0,   8'd0,  8'd5, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
        '{OP_DISPATCH, 8'd0,   8'd0,  8'd7, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
        '{OP_DISPATCH, 8'd0,   8'd0,  8'd9, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
        '{OP_ADD,      8'd1,   8'd0,  8'd5, 8'd2,   8'd0,   1'b0, 1'b0, 8'd0},
        '{OP_DISPATCH, 8'd0,   8'd0,  8'd5, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0}
    };

    hierarchical_fsm_event_dispatch_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // Index of a defined state, or -1 for id zero or an unknown id.
    function automatic int lookup_state(logic [7:0] id);
        int hit;
        hit = -1;
        if (id != 8'd0)
            for (int i = 0; i < state_cnt; i++)
                if (hit < 0 && state_mem[i].id == id)
                    hit = i;
        return hit;
    endfunction

    // Winning transition out of one level: highest priority, then smallest target.
    function automatic int best_transition(logic [7:0] src, logic [7:0] evt);
        int best;
        best = -1;
        for (int i = 0; i < trans_cnt; i++)
        begin
            if (trans_mem[i].source == src && trans_mem[i].evt == evt)
            begin
                if (best < 0)
                    best = i;
                else if (trans_mem[i].pri > trans_mem[best].pri ||
                         (trans_mem[i].pri == trans_mem[best].pri &&
                          trans_mem[i].target < trans_mem[best].target))
                    best = i;
            end
        end
        return best;
    endfunction

    // Apply one request to the shadow tables and return the reply it must produce.
    function automatic reply_t apply_request(op_t op, logic [7:0] sid, logic [7:0] pid,
                                             logic [7:0] eid, logic [7:0] tid,
                                             logic [7:0] pri);
        reply_t     r;
        logic [7:0] level;
        int         depth;
        int         k;
        int         s;
        bit         done;
        r.status = 1'b1;
        case (op)
            OP_DEFINE:
            begin
                if (sid != 8'd0 && lookup_state(sid) < 0 &&
                    (pid == 8'd0 || lookup_state(pid) >= 0) &&
                    state_cnt < HFSM_MAX_STATES)
                begin
                    state_mem[state_cnt].id     = sid;
                    state_mem[state_cnt].parent = pid;
                    state_cnt++;
                    r.status = 1'b0;
                end
            end
            OP_ADD:
            begin
                if (sid != 8'd0 && eid != 8'd0 && tid != 8'd0 &&
                    lookup_state(sid) >= 0 && lookup_state(tid) >= 0 &&
                    trans_cnt < HFSM_MAX_TRANSITIONS)
                begin
                    trans_mem[trans_cnt].source = sid;
                    trans_mem[trans_cnt].evt    = eid;
                    trans_mem[trans_cnt].target = tid;
                    trans_mem[trans_cnt].pri    = pri;
                    trans_cnt++;
                    r.status = 1'b0;
                end
            end
            OP_INIT:
            begin
                if (lookup_state(sid) >= 0)
                begin
                    cur_state = sid;
                    r.status  = 1'b0;
                end
            end
            default:
            begin
                // Climb from the current state; the first level with a match decides.
                level = cur_state;
                depth = 0;
                done  = 1'b0;
                while (!done && level != 8'd0 && depth <= HFSM_MAX_STATES)
                begin
                    k = best_transition(level, eid);
                    if (k >= 0)
                    begin
                        cur_state = trans_mem[k].target;
                        r.status  = 1'b0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        s     = lookup_state(level);
                        level = (s < 0) ? 8'd0 : state_mem[s].parent;
                        depth++;
                    end
                end
            end
        endcase
        r.cur = cur_state;
        r.seq = 0;
        return r;
    endfunction

    function automatic logic [7:0] known_state();
        if (state_cnt == 0)
            return 8'($urandom_range(1, 255));
        return state_mem[$urandom_range(0, state_cnt - 1)].id;
    endfunction

    // Drive one request; hold it until the engine takes it. Bursts end in random gaps.
    task automatic send_request(input op_t op, input logic [7:0] sid, input logic [7:0] pid,
                                input logic [7:0] eid, input logic [7:0] tid,
                                input logic [7:0] pri, input bit typed,
                                input logic want_status, input logic [7:0] want_cur);
        reply_t r;
        int     gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        r = apply_request(op, sid, pid, eid, tid, pri);
        if (op == OP_DISPATCH && r.status == 1'b0)
            moves_taken++;
        if (typed)
        begin
            r.status = want_status;
            r.cur    = want_cur;
        end
        r.seq = sent_count;
        pending_replies = {pending_replies, r};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pri, tid, eid, pid, sid};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
        burst_left--;
    endtask

    // Mostly well-formed requests against defined states, so that chains grow deep and
    // dispatches find matches; the rest is unconstrained noise.
    task automatic send_random();
        op_t        op;
        logic [7:0] sid;
        logic [7:0] pid;
        logic [7:0] eid;
        logic [7:0] tid;
        logic [7:0] pri;
        int         sel;
        sid = 8'($urandom_range(0, 255));
        pid = 8'($urandom_range(0, 255));
        eid = 8'($urandom_range(0, 255));
        tid = 8'($urandom_range(0, 255));
        pri = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            op = OP_DEFINE;
            if ($urandom_range(0, 19) == 0)
                sid = 8'd0;
            case ($urandom_range(0, 9))
                0, 1:       pid = 8'd0;
                2, 3, 4:    pid = (state_cnt == 0) ? 8'd0 : state_mem[state_cnt - 1].id;
                5, 6, 7, 8: pid = known_state();
                default:    ;
            endcase
        end
        else if (sel < 37)
        begin
            op = OP_ADD;
            if ($urandom_range(0, 9) != 0)
                sid = known_state();
            if ($urandom_range(0, 9) != 0)
                tid = known_state();
            if ($urandom_range(0, 9) != 0)
                eid = 8'($urandom_range(1, 6));
            if ($urandom_range(0, 1) != 0)
                pri = 8'($urandom_range(0, 3));
        end
        else if (sel < 47)
        begin
            op = OP_INIT;
            if ($urandom_range(0, 19) > 2)
                sid = known_state();
        end
        else if (sel < 92)
        begin
            op = OP_DISPATCH;
            if ($urandom_range(0, 19) > 2)
                eid = 8'($urandom_range(1, 6));
        end
        else
        begin
            op = op_t'($urandom_range(0, 3));
        end
        send_request(op, sid, pid, eid, tid, pri, 1'b0, 1'b0, 8'd0);
    endtask

    // Reply side: compare each accepted reply with the oldest expectation, then pick
    // the next ready level from runs of random length.
    always @(posedge clk)
    begin : reply_check
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH: unexpected reply status=%0d state=%0d",
                             m_axis_tuser[0], m_axis_tdata);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser[0] !== want.status || m_axis_tdata !== want.cur)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("MISMATCH: request %0d expected status=%0d state=%0d, %s%0d %s%0d",
                                 want.seq, want.status, want.cur,
                                 "got status=", m_axis_tuser[0], "state=", m_axis_tdata);
                end
            end
        end
        if (ready_run == 0)
        begin
            ready_level = ($urandom_range(0, 9) < 7);
            ready_run   = ready_level ? $urandom_range(1, 30) : $urandom_range(1, 8);
        end
        ready_run--;
        m_axis_tready <= ready_level;
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("hierarchical_fsm_event_dispatch_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        // Hold reset low, then release it on a clock edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(dir_rows[i].op, dir_rows[i].sid, dir_rows[i].pid, dir_rows[i].eid,
                         dir_rows[i].tid, dir_rows[i].pri, dir_rows[i].typed,
                         dir_rows[i].status, dir_rows[i].cur);

        for (int i = 0; i < RUN_ITEMS; i++)
            send_random();

        // Drop valid and drain every outstanding reply, then let the engine settle.
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d requests (%0d from the directed table), %0d replies, %0d moves",
                 sent_count, DIR_ROWS, replies_seen, moves_taken);
        $display("tables ended with %0d states and %0d transitions, %0d mismatches",
                 state_cnt, trans_cnt, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("hierarchical_fsm_event_dispatch_unit_tb: done, clean");
        else
            $display("hierarchical_fsm_event_dispatch_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
design/hfsm_pkg.sv
design/hfsm_ram.sv
design/hfsm_match_unit.sv
design/hierarchical_fsm_event_dispatch_unit.sv
tb/hierarchical_fsm_event_dispatch_unit_tb.sv
